[hdl/ookfe_pkg.sv]
// ----------------------------------------------------------------------------
// OOK remote frame encoder package
// Types, constants and symbol timing shared by the encoder modules.
// ----------------------------------------------------------------------------
package ookfe_pkg;

  localparam int unsigned UNIT_W       = 10;
  localparam int unsigned LONG_W       = 13;
  localparam int unsigned SYNC_W       = 14;
  localparam int unsigned DEVICE_BITS  = 26;
  localparam int unsigned FRAME_BITS   = 36;
  localparam int unsigned SYM_IDX_W    = 6;

  localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(250);

  localparam logic [1:0] STATE_ON  = 2'd1;
  localparam logic [1:0] STATE_DIM = 2'd2;

  // Symbol positions inside one frame
  localparam logic [SYM_IDX_W-1:0] SYM_SYNC       = SYM_IDX_W'(0);
  localparam logic [SYM_IDX_W-1:0] SYM_STATE      = SYM_IDX_W'(28);
  localparam logic [SYM_IDX_W-1:0] SYM_CLOSE      = SYM_IDX_W'(33);
  localparam logic [SYM_IDX_W-1:0] SYM_CLOSE_DIM  = SYM_IDX_W'(37);

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [25:0] device_code;
    logic        group_flag;
    logic [1:0]  switch_state;
    logic [3:0]  channel_code;
    logic [3:0]  dim_level;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  first_mark_us;
    logic [13:0] first_space_us;
    logic        has_second;
    logic [9:0]  second_mark_us;
    logic [12:0] second_space_us;
    logic        last;
  } sym_t;

  // Classified frame: data bits in send order from the MSB, plus dimmer mode
  typedef struct packed {
    logic [FRAME_BITS-1:0] bits;
    logic                  dim;
  } frame_t;

endpackage

[hdl/ookfe_front.sv]
// ----------------------------------------------------------------------------
// OOK remote frame encoder front end
// Accepts a command word, classifies its switch state and holds the frame
// descriptor until the queue takes it.
// ----------------------------------------------------------------------------
module ookfe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ookfe_pkg::cmd_t   in_data,
  output logic              push,
  output ookfe_pkg::frame_t push_data,
  input  logic              q_full
);

  logic              desc_valid;
  ookfe_pkg::frame_t desc;
  ookfe_pkg::frame_t desc_next;
  logic              is_on;
  logic              is_dim;

  assign push     = desc_valid && !q_full;
  assign in_stall = desc_valid && q_full;
  assign push_data = desc;

  // States other than on and dimmer send as off
  always_comb begin
    is_on  = (in_data.switch_state == ookfe_pkg::STATE_ON);
    is_dim = (in_data.switch_state == ookfe_pkg::STATE_DIM);
    desc_next.bits = {in_data.device_code, in_data.group_flag, is_on,
                      in_data.channel_code,
                      (is_dim ? in_data.dim_level : 4'd0)};
    desc_next.dim  = is_dim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      desc_valid <= 1'b1;
    end else if (push) begin
      desc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      desc <= desc_next;
    end
  end

endmodule

[hdl/ookfe_queue.sv]
// ----------------------------------------------------------------------------
// OOK remote frame encoder queue
// Short FIFO of frame descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module ookfe_queue #(
  parameter int unsigned QUEUE_DEPTH = ookfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ookfe_pkg::frame_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output ookfe_pkg::frame_t pop_data
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ookfe_pkg::frame_t  store [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign pop_data = store[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/ookfe_back.sv]
// ----------------------------------------------------------------------------
// OOK remote frame encoder back end
// Walks one frame symbol by symbol and drives the registered symbol output.
// ----------------------------------------------------------------------------
module ookfe_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ookfe_pkg::UNIT_W-1:0]      pulse_unit,
  input  logic                              q_valid,
  input  ookfe_pkg::frame_t                 pop_data,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ookfe_pkg::sym_t                   out_data
);

  logic                                busy;
  logic                                dim;
  logic [ookfe_pkg::FRAME_BITS-1:0]    shift;
  logic [ookfe_pkg::SYM_IDX_W-1:0]     idx;
  logic [ookfe_pkg::UNIT_W-1:0]        u;
  logic [ookfe_pkg::LONG_W-1:0]        u5;
  logic [ookfe_pkg::SYNC_W-1:0]        u10;
  logic                                adv;
  logic                                is_close;
  ookfe_pkg::sym_t                     sym;

  // A zero unit sends as one microsecond
  assign u   = (pulse_unit == '0) ? ookfe_pkg::UNIT_W'(1) : pulse_unit;
  assign u5  = {u, 2'b00} + ookfe_pkg::LONG_W'(u);
  assign u10 = {u5, 1'b0};

  assign is_close = (idx == (dim ? ookfe_pkg::SYM_CLOSE_DIM : ookfe_pkg::SYM_CLOSE));
  assign adv      = busy && (!out_valid || !out_stall);
  // Take the next frame while the closing symbol goes out
  assign pop      = q_valid && (!busy || (adv && is_close));

  always_comb begin
    sym.first_mark_us   = u;
    sym.first_space_us  = ookfe_pkg::SYNC_W'(u);
    sym.has_second      = 1'b1;
    sym.second_mark_us  = u;
    sym.second_space_us = ookfe_pkg::LONG_W'(u);
    sym.last            = 1'b0;
    if (idx == ookfe_pkg::SYM_SYNC) begin
      sym.first_space_us  = u10;
      sym.has_second      = 1'b0;
      sym.second_mark_us  = '0;
      sym.second_space_us = '0;
    end else if (is_close) begin
      sym.has_second      = 1'b0;
      sym.second_mark_us  = '0;
      sym.second_space_us = '0;
      sym.last            = 1'b1;
    end else if (dim && idx == ookfe_pkg::SYM_STATE) begin
      // dimmer state symbol: two short pulses
      sym.has_second = 1'b1;
    end else if (shift[ookfe_pkg::FRAME_BITS-1]) begin
      sym.first_space_us = ookfe_pkg::SYNC_W'(u5);
    end else begin
      sym.second_space_us = u5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv) begin
        if (is_close) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shift <= pop_data.bits;
      dim   <= pop_data.dim;
    end else if (adv && idx != ookfe_pkg::SYM_SYNC) begin
      shift <= {shift[ookfe_pkg::FRAME_BITS-2:0], 1'b0};
    end
    if (adv) begin
      out_data <= sym;
    end
  end

endmodule

[hdl/ook_remote_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// OOK remote frame encoder
// Turns one remote command into its on-off-keyed pulse train, one symbol
// of up to two mark/space pulses per output word.
//
//   port       | direction | word
//   -----------+-----------+----------------------------------------------
//   in_*       | in        | command: device, group, state, channel, level
//   out_*      | out       | symbol: marks and spaces in microseconds
//   cfg_wr_*   | in        | pulse unit register, write only
//
// A frame gives 34 output words, or 38 in dimmer state, one per cycle.
// The back end symbol counter sets this: one word per cycle while out_stall
// is low; a queued next frame is taken while the closing word goes out.
// Reset (synchronous) empties the queue, drops any frame in progress and
// sets the pulse unit to 250. out_stall holds the current word and the back
// end; commands keep entering until the queue and front register are full.
// ----------------------------------------------------------------------------
module ook_remote_frame_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = ookfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ookfe_pkg::cmd_t              in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ookfe_pkg::sym_t              out_data,
  input  logic                         cfg_wr_en,
  input  logic [ookfe_pkg::UNIT_W-1:0] cfg_wr_data
);

  logic [ookfe_pkg::UNIT_W-1:0] pulse_unit;
  logic                         push;
  ookfe_pkg::frame_t            push_data;
  logic                         q_full;
  logic                         q_valid;
  logic                         pop;
  ookfe_pkg::frame_t            pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_unit <= ookfe_pkg::UNIT_RESET;
    end else if (cfg_wr_en) begin
      pulse_unit <= cfg_wr_data;
    end
  end

  ookfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  ookfe_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  ookfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pulse_unit (pulse_unit),
    .q_valid    (q_valid),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[tb/ookfe_symbol_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OOK frame encoder symbol checker
// Watches the command, symbol and pulse unit ports of the encoder, predicts
// the pulse train of every accepted command and compares each accepted
// symbol word, field by field, against the oldest predicted word.
// ----------------------------------------------------------------------------
module ookfe_symbol_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  ookfe_pkg::cmd_t              in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  ookfe_pkg::sym_t              out_data,
  input  logic                         cfg_wr_en,
  input  logic [ookfe_pkg::UNIT_W-1:0] cfg_wr_data,
  output int                           fail_count,
  output int                           pending
);

  localparam int unsigned SYNC_MULT  = 10;
  localparam int unsigned LONG_MULT  = 5;
  localparam int          REPORT_MAX = 10;

  logic [ookfe_pkg::UNIT_W-1:0]     pulse_unit;
  logic [ookfe_pkg::FRAME_BITS-1:0] frame_reg;
  ookfe_pkg::sym_t                  symbol_q[$];
  int                               errors = 0;

  task automatic push_symbol(input int unsigned m1, input int unsigned s1,
                             input logic has2, input int unsigned m2,
                             input int unsigned s2, input logic closing);
    ookfe_pkg::sym_t s;
    s.first_mark_us   = 10'(m1);
    s.first_space_us  = 14'(s1);
    s.has_second      = has2;
    s.second_mark_us  = 10'(m2);
    s.second_space_us = 13'(s2);
    s.last            = closing;
    symbol_q.push_back(s);
  endtask

  // one is long-then-short space, zero is short-then-long
  task automatic push_data_bit(input int unsigned u, input logic b);
    if (b) begin
      push_symbol(u, LONG_MULT * u, 1'b1, u, u, 1'b0);
    end else begin
      push_symbol(u, u, 1'b1, u, LONG_MULT * u, 1'b0);
    end
  endtask

  task automatic encode_frame(input ookfe_pkg::cmd_t c);
    int unsigned u;
    logic        is_dim;
    logic        is_on;
    u      = (pulse_unit == '0) ? 1 : int'(pulse_unit);
    is_dim = (c.switch_state == ookfe_pkg::STATE_DIM);
    is_on  = (c.switch_state == ookfe_pkg::STATE_ON);
    frame_reg = {c.device_code, c.group_flag, is_on, c.channel_code,
                 is_dim ? c.dim_level : 4'h0};
    push_symbol(u, SYNC_MULT * u, 1'b0, 0, 0, 1'b0);
    // device code and group bit
    for (int i = ookfe_pkg::FRAME_BITS - 1; i >= 9; i--) push_data_bit(u, frame_reg[i]);
    if (is_dim) begin
      push_symbol(u, u, 1'b1, u, u, 1'b0);
    end else begin
      push_data_bit(u, frame_reg[8]);
    end
    for (int i = 7; i >= 4; i--) push_data_bit(u, frame_reg[i]);
    if (is_dim) begin
      for (int i = 3; i >= 0; i--) push_data_bit(u, frame_reg[i]);
    end
    push_symbol(u, u, 1'b0, 0, 0, 1'b1);
  endtask

  task automatic report(input string what, input ookfe_pkg::sym_t e,
                        input ookfe_pkg::sym_t a);
    errors++;
    if (errors <= REPORT_MAX) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected fm=%0d fs=%0d h=%0d sm=%0d ss=%0d l=%0d",
               e.first_mark_us, e.first_space_us, e.has_second,
               e.second_mark_us, e.second_space_us, e.last);
      $display("  actual   fm=%0d fs=%0d h=%0d sm=%0d ss=%0d l=%0d",
               a.first_mark_us, a.first_space_us, a.has_second,
               a.second_mark_us, a.second_space_us, a.last);
    end
  endtask

  always @(posedge clk) begin
    ookfe_pkg::sym_t want;
    if (rst) begin
      pulse_unit <= ookfe_pkg::UNIT_RESET;
      symbol_q.delete();
    end else begin
      if (cfg_wr_en) pulse_unit <= cfg_wr_data;
      if (in_valid && !in_stall) encode_frame(in_data);
      if (out_valid && !out_stall) begin
        if (symbol_q.size() == 0) begin
          report("symbol word with nothing predicted", '0, out_data);
        end else begin
          want = symbol_q.pop_front();
          if (want.first_mark_us   !== out_data.first_mark_us   ||
              want.first_space_us  !== out_data.first_space_us  ||
              want.has_second      !== out_data.has_second      ||
              want.second_mark_us  !== out_data.second_mark_us  ||
              want.second_space_us !== out_data.second_space_us ||
              want.last            !== out_data.last) begin
            report("symbol word differs", want, out_data);
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= symbol_q.size();
  end

endmodule

[tb/tb_ook_remote_frame_encoder_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OOK remote frame encoder testbench
// Sends directed and random remote commands in bursts under several pulse
// unit settings while the symbol port stalls on its own pattern; a checker
// beside the encoder predicts and compares every symbol word.
// ----------------------------------------------------------------------------
module tb_ook_remote_frame_encoder_unit;

  localparam logic [1:0] STATE_OFF     = 2'd0;
  localparam logic [1:0] STATE_OFF_ALT = 2'd3;
  localparam int         PHASES        = 6;
  localparam int         PHASE_ITEMS   = 38;
  localparam int         DRAIN_PAD     = 10;
  localparam int         TAIL_CYCLES   = 40;
  localparam int         IDLE_LIMIT    = 4000;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_e;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  ookfe_pkg::cmd_t              in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  ookfe_pkg::sym_t              out_data;
  logic                         cfg_wr_en = 1'b0;
  logic [ookfe_pkg::UNIT_W-1:0] cfg_wr_data = '0;

  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          gap_max = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  ook_remote_frame_encoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ookfe_symbol_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // switch the stall pattern whenever its random countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(3));
      stall_left <= $urandom_range(64, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(3) != 0);
      default:     out_stall <= ((stall_left % 16) < 9);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic ookfe_pkg::cmd_t make_cmd(input logic [25:0] dev, input logic grp,
                                               input logic [1:0] st, input logic [3:0] ch,
                                               input logic [3:0] lvl);
    ookfe_pkg::cmd_t c;
    c.device_code  = dev;
    c.group_flag   = grp;
    c.switch_state = st;
    c.channel_code = ch;
    c.dim_level    = lvl;
    return c;
  endfunction

  function automatic ookfe_pkg::cmd_t random_cmd();
    logic [25:0] dev;
    case ($urandom_range(7))
      0:       dev = '0;
      1:       dev = '1;
      default: dev = 26'($urandom);
    endcase
    return make_cmd(dev, 1'($urandom), 2'($urandom), 4'($urandom), 4'($urandom));
  endfunction

  // call at a rising edge; returns after the edge that takes the word and any idle gap
  task automatic send_cmd(input ookfe_pkg::cmd_t c);
    bit taken;
    int gap;
    in_data  <= c;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(12);
    end
  endtask

  // let the checker count settle before watching it
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_unit(input logic [ookfe_pkg::UNIT_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [ookfe_pkg::UNIT_W-1:0] unit_plan [PHASES];
    int                           gap_plan  [PHASES];
    unit_plan = '{10'd1, 10'd1023, 10'd0, 10'($urandom_range(1, 1023)),
                  10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023))};
    gap_plan  = '{0, 6, 15, 3, 0, 10};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed frames at the reset unit
    gap_max = 4;
    send_cmd(make_cmd('0, 1'b0, STATE_OFF, 4'h0, 4'h0));
    send_cmd(make_cmd('1, 1'b1, ookfe_pkg::STATE_ON, 4'hF, 4'hF));
    send_cmd(make_cmd(26'h2AAAAAA, 1'b1, ookfe_pkg::STATE_DIM, 4'h5, 4'hA));
    send_cmd(make_cmd(26'h1555555, 1'b0, ookfe_pkg::STATE_DIM, 4'hA, 4'h5));
    send_cmd(make_cmd(26'h3000001, 1'b0, STATE_OFF_ALT, 4'h9, 4'hF));
    send_cmd(make_cmd('0, 1'b0, ookfe_pkg::STATE_DIM, 4'h0, 4'h0));
    send_cmd(make_cmd('1, 1'b1, ookfe_pkg::STATE_DIM, 4'hF, 4'hF));
    send_cmd(make_cmd(26'h0000001, 1'b1, STATE_OFF, 4'h6, 4'hF));
    send_cmd(make_cmd(26'h0000001, 1'b0, ookfe_pkg::STATE_ON, 4'h1, 4'h0));
    send_cmd(make_cmd(26'h2000000, 1'b1, STATE_OFF_ALT, 4'h8, 4'h0));

    // random frames, one pulse unit per phase, extremes and zero first
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_unit(unit_plan[p]);
      gap_max    = gap_plan[p];
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
